// ----- src/wus_pkg.sv -----
`default_nettype none
package wus_pkg;

  // Lattice defaults
  localparam int SIDE_DEFAULT       = 32;
  localparam int COUNT_BITS_DEFAULT = 8;

  // Fixed field widths of the ports
  localparam int COORD_W     = 5;
  localparam int DIR_W       = 2;
  localparam int RAND_W      = 16;
  localparam int BETA_W      = 16;
  localparam int TOTAL_OUT_W = 19;

  // Fraction bits of beta (Q4.12)
  localparam int BETA_FRAC = 12;

  // Beta after reset: 1.0 in Q4.12
  localparam logic [BETA_W-1:0] BETA_RESET = BETA_W'(4096);

  // Move directions
  localparam logic [DIR_W-1:0] DIR_PLUS_COL  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_MINUS_COL = 2'd1;
  localparam logic [DIR_W-1:0] DIR_MINUS_ROW = 2'd2;
  localparam logic [DIR_W-1:0] DIR_PLUS_ROW  = 2'd3;

endpackage
`default_nettype wire

// ----- src/worm_update_step_top.sv -----
`default_nettype none
// Worm update step: one worm Monte Carlo move per transaction on a periodic
// SIDE x SIDE lattice of x and y bond counts.
// Configuration: cfg_we writes cfg_wdata into beta (Q4.12) at a rising edge;
// write it only while busy is low and no result is pending.
// Input: a transaction is taken at a rising edge with start high and busy
// low (create, direction, rand_fraction, new_row, new_col).
// Output: done is high for exactly one cycle with head_row_out, head_col_out,
// bond_total, accepted and closed; the receiver must take it then.
// Sequence: the registered bond memory read, the shared multiplier register
// and the compare and write-back step lie between the accepting edge and
// done; a new transaction can be taken in the cycle in which done is high,
// and none is taken before then.
// Reset: rst (synchronous) zeroes head, tail and total, sets beta to 1.0 and
// starts a pass that clears all SIDE*SIDE entries (1024 at the default size)
// of both bond memories, one entry per cycle; busy is high during the pass.
// Configuration writes are taken during the pass.
module worm_update_step_top #(
  parameter int SIDE       = wus_pkg::SIDE_DEFAULT,
  parameter int COUNT_BITS = wus_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [wus_pkg::BETA_W-1:0]       cfg_wdata,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             create,
  input  wire logic [wus_pkg::DIR_W-1:0]        direction,
  input  wire logic [wus_pkg::RAND_W-1:0]       rand_fraction,
  input  wire logic [wus_pkg::COORD_W-1:0]      new_row,
  input  wire logic [wus_pkg::COORD_W-1:0]      new_col,
  output logic                                  done,
  output logic      [wus_pkg::COORD_W-1:0]      head_row_out,
  output logic      [wus_pkg::COORD_W-1:0]      head_col_out,
  output logic      [wus_pkg::TOTAL_OUT_W-1:0]  bond_total,
  output logic                                  accepted,
  output logic                                  closed
);

  import wus_pkg::*;

  localparam int CELLS  = SIDE * SIDE;
  localparam int ROW_W  = $clog2(SIDE);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int MB_W   = (COUNT_BITS + 1 > BETA_W) ? COUNT_BITS + 1 : BETA_W;
  localparam int PROD_W = RAND_W + MB_W;
  localparam int DEL_SHIFT = RAND_W + BETA_FRAC;
  localparam int CRE_SHIFT = RAND_W - BETA_FRAC;
  localparam int CMP_W  = (PROD_W > COUNT_BITS + DEL_SHIFT) ? PROD_W
                                                             : COUNT_BITS + DEL_SHIFT;
  localparam longint unsigned TOTAL_MAX =
    64'(2) * 64'(SIDE) * 64'(SIDE) * ((64'(1) << COUNT_BITS) - 64'(1));
  localparam int TOTAL_W = $clog2(TOTAL_MAX + 64'(1));
  localparam int IN_SITES = 2 ** COORD_W;

  localparam logic [ROW_W-1:0]      LAST_COORD = ROW_W'(SIDE - 1);
  localparam logic [ADDR_W-1:0]     LAST_ADDR  = ADDR_W'(CELLS - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_DECIDE
  } state_t;

  state_t state;

  // Architectural state
  logic [BETA_W-1:0]  beta;
  logic [ROW_W-1:0]   head_row;
  logic [ROW_W-1:0]   head_col;
  logic [ROW_W-1:0]   tail_row;
  logic [ROW_W-1:0]   tail_col;
  logic [TOTAL_W-1:0] total_links;

  // Per-transaction registers
  logic [ADDR_W-1:0]     clr_addr;
  logic [ADDR_W-1:0]     link_addr;
  logic                  link_is_y;
  logic                  create_q;
  logic [DIR_W-1:0]      dir_q;
  logic [RAND_W-1:0]     rand_q;
  logic                  closed_q;
  logic [COUNT_BITS-1:0] nb;
  logic [PROD_W-1:0]     prod;

  // Relocation site modulo SIDE, as a constant table
  logic [ROW_W-1:0] mod_tab [IN_SITES];

  for (genvar g = 0; g < IN_SITES; g++) begin : g_mod
    assign mod_tab[g] = ROW_W'(g % SIDE);
  end

  // Close the worm if head meets tail
  logic             close_c;
  logic [ROW_W-1:0] eff_row;
  logic [ROW_W-1:0] eff_col;
  logic [ROW_W-1:0] link_row_c;
  logic [ROW_W-1:0] link_col_c;
  logic [ADDR_W-1:0] link_addr_c;

  always_comb begin
    close_c = (head_row == tail_row) && (head_col == tail_col);
    eff_row = close_c ? mod_tab[new_row] : head_row;
    eff_col = close_c ? mod_tab[new_col] : head_col;
    link_row_c = eff_row;
    link_col_c = eff_col;
    case (direction)
      DIR_MINUS_COL: begin
        link_col_c = (eff_col == '0) ? LAST_COORD : eff_col - ROW_W'(1);
      end
      DIR_MINUS_ROW: begin
        link_row_c = (eff_row == '0) ? LAST_COORD : eff_row - ROW_W'(1);
      end
      default: begin
      end
    endcase
    link_addr_c = ADDR_W'(ADDR_W'(link_row_c) * ADDR_W'(SIDE) + ADDR_W'(link_col_c));
  end

  // Bond memories
  logic                  x_we;
  logic                  y_we;
  logic [ADDR_W-1:0]     ram_addr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [COUNT_BITS-1:0] x_rdata;
  logic [COUNT_BITS-1:0] y_rdata;

  wus_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (CELLS)
  ) u_x_links (
    .clk   (clk),
    .we    (x_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (x_rdata)
  );

  wus_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (CELLS)
  ) u_y_links (
    .clk   (clk),
    .we    (y_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (y_rdata)
  );

  // Shared multiplier: r*(nb+1) on create, r*beta on delete
  logic [COUNT_BITS-1:0] nb_c;
  logic [MB_W-1:0]       mul_b;
  logic [PROD_W-1:0]     prod_c;

  always_comb begin
    nb_c   = link_is_y ? y_rdata : x_rdata;
    mul_b  = create_q ? MB_W'(MB_W'(nb_c) + MB_W'(1)) : MB_W'(beta);
    prod_c = PROD_W'(rand_q) * PROD_W'(mul_b);
  end

  // Acceptance test and next state of the worm
  logic [CMP_W-1:0]      thr;
  logic                  acc_c;
  logic [COUNT_BITS-1:0] count_next;
  logic [ROW_W-1:0]      head_row_next;
  logic [ROW_W-1:0]      head_col_next;
  logic [TOTAL_W-1:0]    total_next;

  always_comb begin
    if (create_q) begin
      thr   = CMP_W'(beta) << CRE_SHIFT;
      acc_c = (nb != COUNT_MAX) && (CMP_W'(prod) < thr);
    end else begin
      thr   = CMP_W'(nb) << DEL_SHIFT;
      acc_c = CMP_W'(prod) < thr;
    end
    count_next    = create_q ? nb + COUNT_BITS'(1) : nb - COUNT_BITS'(1);
    head_row_next = head_row;
    head_col_next = head_col;
    total_next    = total_links;
    if (acc_c) begin
      total_next = create_q ? total_links + TOTAL_W'(1) : total_links - TOTAL_W'(1);
      case (dir_q)
        DIR_PLUS_COL: begin
          head_col_next = (head_col == LAST_COORD) ? '0 : head_col + ROW_W'(1);
        end
        DIR_MINUS_COL: begin
          head_col_next = (head_col == '0) ? LAST_COORD : head_col - ROW_W'(1);
        end
        DIR_MINUS_ROW: begin
          head_row_next = (head_row == '0) ? LAST_COORD : head_row - ROW_W'(1);
        end
        default: begin
          head_row_next = (head_row == LAST_COORD) ? '0 : head_row + ROW_W'(1);
        end
      endcase
    end
  end

  // Memory port steering: clear sweep, read on accept, write back on decide
  always_comb begin
    case (state)
      ST_CLEAR: ram_addr = clr_addr;
      ST_IDLE:  ram_addr = link_addr_c;
      default:  ram_addr = link_addr;
    endcase
    ram_wdata = (state == ST_CLEAR) ? '0 : count_next;
    x_we = (state == ST_CLEAR) || ((state == ST_DECIDE) && acc_c && !link_is_y);
    y_we = (state == ST_CLEAR) || ((state == ST_DECIDE) && acc_c && link_is_y);
  end

  assign busy = (state != ST_IDLE);

  // Widen before cutting the outputs to their port widths
  logic [ROW_W+COORD_W-1:0]       row_ext;
  logic [ROW_W+COORD_W-1:0]       col_ext;
  logic [TOTAL_W+TOTAL_OUT_W-1:0] total_ext;

  always_comb begin
    row_ext   = (ROW_W + COORD_W)'(head_row_next);
    col_ext   = (ROW_W + COORD_W)'(head_col_next);
    total_ext = (TOTAL_W + TOTAL_OUT_W)'(total_next);
  end

  // Sequencer, state and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      beta        <= BETA_RESET;
      head_row    <= '0;
      head_col    <= '0;
      tail_row    <= '0;
      tail_col    <= '0;
      total_links <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        beta <= cfg_wdata;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            head_row  <= eff_row;
            head_col  <= eff_col;
            if (close_c) begin
              tail_row <= eff_row;
              tail_col <= eff_col;
            end
            link_addr <= link_addr_c;
            link_is_y <= (direction == DIR_MINUS_ROW) || (direction == DIR_PLUS_ROW);
            create_q  <= create;
            dir_q     <= direction;
            rand_q    <= rand_fraction;
            closed_q  <= close_c;
            state     <= ST_MUL;
          end
        end
        ST_MUL: begin
          nb    <= nb_c;
          prod  <= prod_c;
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          head_row     <= head_row_next;
          head_col     <= head_col_next;
          total_links  <= total_next;
          head_row_out <= row_ext[COORD_W-1:0];
          head_col_out <= col_ext[COORD_W-1:0];
          bond_total   <= total_ext[TOTAL_OUT_W-1:0];
          accepted     <= acc_c;
          closed       <= closed_q;
          done         <= 1'b1;
          state        <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- src/wus_ram.sv -----
`default_nettype none
module wus_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire
